@@ hw/rtl/msls_pkg.sv @@
`default_nettype none
package msls_pkg;
    localparam int MaxTasks    = 64;
    localparam int MaxMachines = 16;
    localparam int DurBits     = 16;
    localparam int IdxBits     = 6;
    localparam int CntBits     = 7;
    localparam int MachBits    = 4;
    localparam int LoadBits    = 23;
    localparam int SpanBits    = 22;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SORT_RD_KEY,
        ST_SORT_RD_PREV,
        ST_SORT_CMP,
        ST_PLACE_RD,
        ST_PLACE_ADD,
        ST_SPAN,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/msls_mem.sv @@
`default_nettype none
// Generic single write, single read RAM with registered read data.
module msls_mem #(
    parameter int Depth = 64,
    parameter int Width = 16,
    parameter int AddrBits = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AddrBits-1:0] i_waddr,
    input  wire logic [Width-1:0]    i_wdata,
    input  wire logic [AddrBits-1:0] i_raddr,
    output logic      [Width-1:0]    o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/mixed_spt_lpt_list_scheduler.sv @@
`default_nettype none
// Mixed SPT/LPT list scheduler. Durations are taken one per cycle and stored
// in arrival order; the transfer with i_last_task closes the set (tasks past
// 64 are dropped, but their last bit still closes). The first floor(n/2)
// tasks are then stably insertion-sorted ascending, the rest descending, and
// placed in that order onto the least-loaded machine (lowest number on a
// tie). One result per task follows in placement order, all carrying the
// final makespan. The order RAM is filled one entry per task; the sort
// reads each key and then shifts entries one at a time (O(n^2) worst case,
// one read port on the order RAM); placement scans every machine per task,
// the span scan reads every machine once, and emission holds each result
// while the output is stalled. Input stall stays high from the closing
// transfer until the last result is taken. machine_count is written over
// its own valid/ready port; 0 acts as 1 and values above 16 act as 16.
module mixed_spt_lpt_list_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_machine_count,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_task_duration,
    input  wire logic        i_last_task,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_task_index,
    output logic [4:0]       o_assigned_machine,
    output logic [21:0]      o_makespan,
    output logic             o_last_result
);
    localparam int IB = msls_pkg::IdxBits;
    localparam int CB = msls_pkg::CntBits;
    localparam int MB = msls_pkg::MachBits;
    localparam int LB = msls_pkg::LoadBits;
    localparam int DB = msls_pkg::DurBits;

    msls_pkg::t_state r_state, n_state;
    logic [4:0]  r_mcount;
    logic [CB-1:0] r_cnt;
    logic [CB-1:0] r_i;
    logic [IB-1:0] r_j, r_lo;
    logic [CB-1:0] r_hi;
    logic          r_desc;
    logic [IB-1:0] r_key;
    logic [DB-1:0] r_kd;
    logic [IB-1:0] r_prev;
    logic [MB-1:0] r_k, r_best;
    logic [LB-1:0] r_bestload, r_span;
    logic [LB-1:0] r_load [msls_pkg::MaxMachines];
    logic          r_phase; // 0: key read, 1: prev read (sort); place step
    logic          r_ovalid;
    logic [IB-1:0] r_oidx;
    logic [MB-1:0] r_omach;
    logic          r_olast;

    // memories
    logic          dur_we;
    logic [IB-1:0] dur_waddr, dur_raddr;
    logic [DB-1:0] dur_rdata;
    logic          ord_we;
    logic [IB-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic          asg_we;
    logic [IB-1:0] asg_addr;
    logic [MB-1:0] asg_wdata;
    logic [MB-1:0] asg_rdata;

    msls_mem #(.Depth(msls_pkg::MaxTasks), .Width(DB), .AddrBits(IB)) u_dur (
        .i_clk(i_clk), .i_we(dur_we), .i_waddr(dur_waddr),
        .i_wdata(i_task_duration[DB-1:0]), .i_raddr(dur_raddr), .o_rdata(dur_rdata));
    msls_mem #(.Depth(msls_pkg::MaxTasks), .Width(IB), .AddrBits(IB)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr),
        .i_wdata(ord_wdata), .i_raddr(ord_raddr), .o_rdata(ord_rdata));
    msls_mem #(.Depth(msls_pkg::MaxTasks), .Width(MB), .AddrBits(IB)) u_asg (
        .i_clk(i_clk), .i_we(asg_we), .i_waddr(asg_addr),
        .i_wdata(asg_wdata), .i_raddr(asg_addr), .o_rdata(asg_rdata));

    logic in_xfer, out_xfer;
    logic [4:0] m_eff;
    logic [MB-1:0] m_last;
    logic move;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_ovalid && !i_stall;
    assign o_stall  = (r_state != msls_pkg::ST_LOAD);
    assign o_cfg_ready = (r_state == msls_pkg::ST_LOAD);
    assign m_eff  = (r_mcount == 5'd0) ? 5'd1 :
                    (r_mcount > 5'd16) ? 5'd16 : r_mcount;
    assign m_last = MB'(m_eff - 5'd1);
    // dur_rdata here holds the duration of the previous entry
    assign move = r_desc ? (dur_rdata < r_kd) : (dur_rdata > r_kd);
    // winner of the scan including the machine compared this cycle
    assign asg_wdata = (r_load[r_k] < r_bestload) ? r_k : r_best;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msls_pkg::ST_LOAD: if (in_xfer && i_last_task) n_state = msls_pkg::ST_INIT;
            msls_pkg::ST_INIT: if (CB'(r_i) + 1 >= r_cnt) n_state = msls_pkg::ST_SORT_RD_KEY;
            msls_pkg::ST_SORT_RD_KEY: begin
                if (CB'(r_i) >= r_hi) begin
                    n_state = r_desc || r_hi == r_cnt ? msls_pkg::ST_PLACE_RD
                                                      : msls_pkg::ST_SORT_RD_KEY;
                end else begin
                    n_state = msls_pkg::ST_SORT_RD_PREV;
                end
            end
            msls_pkg::ST_SORT_RD_PREV: n_state = msls_pkg::ST_SORT_CMP;
            msls_pkg::ST_SORT_CMP:     n_state = (!r_phase || ((r_j != r_lo) && move))
                                               ? msls_pkg::ST_SORT_CMP
                                               : msls_pkg::ST_SORT_RD_KEY;
            msls_pkg::ST_PLACE_RD:  n_state = (CB'(r_i) >= r_cnt) ? msls_pkg::ST_SPAN
                                                                  : msls_pkg::ST_PLACE_ADD;
            msls_pkg::ST_PLACE_ADD: if (r_phase && r_k == m_last)
                                        n_state = msls_pkg::ST_PLACE_RD;
            msls_pkg::ST_SPAN:      if (r_k == m_last) n_state = msls_pkg::ST_EMIT_RD;
            msls_pkg::ST_EMIT_RD:   n_state = msls_pkg::ST_EMIT_OUT;
            msls_pkg::ST_EMIT_OUT:  if (out_xfer || !r_ovalid) begin
                                        n_state = r_olast && r_ovalid ? msls_pkg::ST_LOAD
                                                : (r_ovalid ? msls_pkg::ST_EMIT_RD
                                                            : msls_pkg::ST_EMIT_OUT);
                                    end
            default: n_state = msls_pkg::ST_LOAD;
        endcase
    end

    // memory controls
    always_comb begin
        dur_we = 1'b0; dur_waddr = r_cnt[IB-1:0]; dur_raddr = r_key;
        ord_we = 1'b0; ord_waddr = r_j; ord_wdata = r_key; ord_raddr = r_i[IB-1:0];
        asg_we = 1'b0; asg_addr = r_i[IB-1:0];
        unique case (r_state)
            msls_pkg::ST_LOAD: dur_we = in_xfer && (r_cnt < CB'(msls_pkg::MaxTasks));
            msls_pkg::ST_INIT: begin
                ord_we = 1'b1; ord_waddr = r_i[IB-1:0]; ord_wdata = r_i[IB-1:0];
            end
            msls_pkg::ST_SORT_RD_KEY:  ord_raddr = r_i[IB-1:0];
            msls_pkg::ST_SORT_RD_PREV: begin
                ord_raddr = r_j - 1'b1;
                dur_raddr = ord_rdata;
            end
            msls_pkg::ST_SORT_CMP: begin
                if (!r_phase) begin
                    dur_raddr = ord_rdata;  // prev duration read
                    ord_raddr = r_j - 1'b1;
                end else begin
                    dur_raddr = r_prev;
                    ord_raddr = r_j - 2'd2; // next prev after a shift
                end
                if (r_phase && (r_j != r_lo) && move) begin
                    ord_we = 1'b1; ord_waddr = r_j; ord_wdata = r_prev;
                end else if (r_phase) begin
                    ord_we = 1'b1; ord_waddr = r_j; ord_wdata = r_key;
                end
            end
            msls_pkg::ST_PLACE_RD:  ord_raddr = r_i[IB-1:0];
            msls_pkg::ST_PLACE_ADD: begin
                ord_raddr = r_i[IB-1:0];
                dur_raddr = ord_rdata;
                if (r_phase && r_k == m_last) asg_we = 1'b1;
            end
            msls_pkg::ST_EMIT_RD:   ord_raddr = r_i[IB-1:0];
            default: ;
        endcase
    end

    // Sort micro-sequence: RD_KEY issues order[i]; RD_PREV latches key, issues
    // dur[key] and order[j-1]; CMP phase 0 latches kd/prev and issues
    // dur[prev]; CMP phase 1 compares, shifts (issuing order[j-2]) or drops
    // the key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msls_pkg::ST_LOAD;
            r_mcount <= 5'd1;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_phase  <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_mcount <= i_cfg_machine_count;
            if (out_xfer) r_ovalid <= 1'b0;
            unique case (r_state)
                msls_pkg::ST_LOAD: begin
                    r_i <= '0;
                    if (in_xfer) begin
                        if (r_cnt < CB'(msls_pkg::MaxTasks)) r_cnt <= r_cnt + 1'b1;
                    end
                end
                msls_pkg::ST_INIT: begin
                    if (CB'(r_i) + 1 >= r_cnt) begin
                        r_lo   <= '0;
                        r_hi   <= r_cnt >> 1;
                        r_desc <= 1'b0;
                        r_i    <= CB'(1);
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                msls_pkg::ST_SORT_RD_KEY: begin
                    r_phase <= 1'b0;
                    r_j     <= r_i[IB-1:0];
                    if (CB'(r_i) >= r_hi) begin
                        if (!r_desc && r_hi != r_cnt) begin
                            r_desc <= 1'b1;
                            r_lo   <= r_hi[IB-1:0];
                            r_hi   <= r_cnt;
                            r_i    <= r_hi + 1'b1;
                        end else begin
                            r_i <= '0;
                            for (int k = 0; k < msls_pkg::MaxMachines; k++) r_load[k] <= '0;
                        end
                    end
                end
                msls_pkg::ST_SORT_RD_PREV: r_key <= ord_rdata;
                msls_pkg::ST_SORT_CMP: begin
                    if (!r_phase) begin
                        if (r_j == r_i[IB-1:0]) r_kd <= dur_rdata; // first compare: key dur
                        r_prev  <= ord_rdata;
                        r_phase <= 1'b1;
                    end else if ((r_j != r_lo) && move) begin
                        r_j     <= r_j - 1'b1;
                        r_phase <= 1'b0;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_phase <= 1'b0;
                    end
                end
                msls_pkg::ST_PLACE_RD: begin
                    r_k <= '0; r_phase <= 1'b0;
                    r_best <= '0; r_bestload <= r_load[0];
                    if (CB'(r_i) >= r_cnt) begin
                        r_span <= '0;
                    end
                end
                msls_pkg::ST_PLACE_ADD: begin
                    // phase 0 waits for the order read; phase 1 scans machines
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        if (r_load[r_k] < r_bestload) begin
                            r_best <= r_k; r_bestload <= r_load[r_k];
                        end
                        if (r_k == m_last) begin
                            if (r_load[r_k] < r_bestload)
                                r_load[r_k] <= r_load[r_k] + LB'(dur_rdata);
                            else
                                r_load[r_best] <= r_bestload + LB'(dur_rdata);
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                msls_pkg::ST_SPAN: begin
                    if (r_load[r_k] > r_span) r_span <= r_load[r_k];
                    r_k <= r_k + 1'b1;
                    r_i <= '0;
                end
                msls_pkg::ST_EMIT_RD: ;
                msls_pkg::ST_EMIT_OUT: begin
                    if (!r_ovalid || out_xfer) begin
                        if (r_ovalid && r_olast) begin
                            r_cnt <= '0;
                        end else if (!r_ovalid || out_xfer) begin
                            if (!r_ovalid) begin
                                r_ovalid <= 1'b1;
                                r_oidx   <= ord_rdata;
                                r_omach  <= asg_rdata;
                                r_olast  <= (CB'(r_i) + 1 == r_cnt);
                                r_i      <= r_i + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_task_index       = r_oidx;
    assign o_assigned_machine = {1'b0, r_omach} + 5'd1;
    assign o_makespan         = r_span[21:0];
    assign o_last_result      = r_olast;

    ast_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall) else $error("input open while results pending");
    ast_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_task_index)))
        else $error("result changed under stall");
    ast_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CB'(msls_pkg::MaxTasks)) else $error("count overflow");
endmodule
`default_nettype wire
